// File: src/sseq_pkg.sv
// ----------------------------------------------------------------------------
// sseq_pkg
// Shared types and codes for the sorted event queue and its cells.
// ----------------------------------------------------------------------------
package sseq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] evt_time;
    logic [15:0] station;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// File: src/sseq_cell.sv
// ----------------------------------------------------------------------------
// sseq_cell
// One slot of the sorted chain. Compares its entry against the incoming time,
// takes the new entry or its lower neighbor on insert, its upper on remove.
// ----------------------------------------------------------------------------
module sseq_cell (
  input  logic                clk_i,
  input  sseq_pkg::cell_ctrl_t ctrl_i,
  input  sseq_pkg::entry_t    new_i,
  input  logic                occ_i,
  input  sseq_pkg::entry_t    prev_i,
  input  logic                prev_open_i,
  input  sseq_pkg::entry_t    next_i,
  output logic                open_o,
  output sseq_pkg::entry_t    ent_o
);
  import sseq_pkg::*;

  entry_t ent_q, ent_d;

  // open: new entry belongs at or below this slot
  assign open_o = !occ_i || (ent_q.evt_time > new_i.evt_time);
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.insert && open_o) begin
      ent_d = prev_open_i ? prev_i : new_i;
    end else if (ctrl_i.remove) begin
      ent_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// File: src/stable_sorted_event_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_event_queue
// Bounded stable priority queue of timed events held as a shift chain of
// cells in ascending time order; cell 0 holds the earliest entry.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | word
// in      | input     | in_valid_i/in_ready_o | kind, event_time, station_id
// out     | output    | out_valid_o/out_ready_i| removed_*, status, occupancy
//
// One word per cycle while the output is not stalled: every cell compares and shifts in parallel in the cycle
// the word is accepted, and the result is registered for the next cycle.
// Reset empties the queue (count to zero); cell contents are not cleared.
// A stalled result holds in the output register; a new word is taken in the
// same cycle the held result leaves.
// ----------------------------------------------------------------------------
module stable_sorted_event_queue #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] event_time_i,
  input  logic [15:0] station_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        removed_valid_o,
  output logic [31:0] removed_time_o,
  output logic [15:0] removed_station_o,
  output logic [1:0]  status_o,
  output logic [6:0]  occupancy_o
);
  import sseq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            full, empty;
  cell_ctrl_t      ctrl;
  entry_t          new_ent;
  entry_t          ent  [CAPACITY];
  logic            open [CAPACITY];

  logic            out_valid_q;
  logic            rm_valid_q, rm_valid_d;
  entry_t          rm_ent_q, rm_ent_d;
  status_e         status_q, status_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);

  assign new_ent.evt_time = event_time_i;
  assign new_ent.station  = station_id_i;
  assign ctrl.insert      = accept && (kind_i == KIND_INSERT) && !full;
  assign ctrl.remove      = accept && (kind_i == KIND_REMOVE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_w, next_w;
    logic   prev_open_w;
    logic   occ_w;

    assign occ_w = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign prev_w      = '0;
      assign prev_open_w = 1'b0;
    end else begin : g_mid
      assign prev_w      = ent[i-1];
      assign prev_open_w = open[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = ent[i+1];
    end

    sseq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_ent),
      .occ_i       (occ_w),
      .prev_i      (prev_w),
      .prev_open_i (prev_open_w),
      .next_i      (next_w),
      .open_o      (open[i]),
      .ent_o       (ent[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    rm_valid_d = 1'b0;
    rm_ent_d   = '0;
    status_d   = STATUS_OK;
    if (kind_i == KIND_INSERT) begin
      if (full) begin
        status_d = STATUS_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        rm_valid_d = 1'b1;
        rm_ent_d   = ent[0];
        count_d    = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rm_valid_q <= rm_valid_d;
      rm_ent_q   <= rm_ent_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign removed_valid_o   = rm_valid_q;
  assign removed_time_o    = rm_ent_q.evt_time;
  assign removed_station_o = rm_ent_q.station;
  assign status_o          = status_q;
  assign occupancy_o       = 7'(count_q);

endmodule

// File: src/sseq_checker.sv
// ----------------------------------------------------------------------------
// sseq_checker
// Port-level checks on the sorted event queue, bound to the top level.
// ----------------------------------------------------------------------------
module sseq_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        removed_valid_o,
  input logic [31:0] removed_time_o,
  input logic [15:0] removed_station_o,
  input logic [1:0]  status_o,
  input logic [6:0]  occupancy_o
);
  import sseq_pkg::*;

  // held result must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(removed_valid_o)
      && $stable(removed_time_o) && $stable(removed_station_o)
      && $stable(status_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  // input stalls only behind a held result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |->
      !removed_valid_o && occupancy_o == 7'd0)
    else $error("empty remove with entries");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |->
      !removed_valid_o && occupancy_o == 7'(CAPACITY))
    else $error("dropped insert with free slot");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_valid_o |-> status_o == STATUS_OK)
    else $error("removed word with error status");

endmodule

bind stable_sorted_event_queue sseq_checker #(.CAPACITY(CAPACITY)) u_sseq_checker (.*);

// File: tb/stable_sorted_event_queue_test.sv
// ----------------------------------------------------------------------------
// stable_sorted_event_queue_test
// Drives insert and remove words into the sorted event queue and checks each
// result word against a behavioral copy of the queue kept in the bench or
// against a table row's typed word. A short table covers the empty corner,
// time extremes and the ordering of equal times; random fill, drain and mixed
// runs follow under varied idling, including one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_sorted_event_queue_test;
  import sseq_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int RAND_PER_PHASE = 410;
  localparam int HOLD_CYCLES    = 200;
  localparam int STALL_LIMIT    = 4000;
  localparam int NUM_ROWS       = 22;

  typedef struct packed {
    logic        found;
    logic [31:0] evt_time;
    logic [15:0] station;
    status_e     status;
    logic [6:0]  occupancy;
  } result_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] evt_time;
    logic [15:0] station;
    logic        typed;
    result_t     want;
  } row_t;

  localparam result_t ANY = '{1'b0, 32'h0, 16'h0, STATUS_OK, 7'd0};

  localparam row_t ROWS [NUM_ROWS] = '{
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b1,
      '{1'b0, 32'h0, 16'h0, STATUS_EMPTY, 7'd0}},
    '{KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
      '{1'b0, 32'h0, 16'h0, STATUS_OK, 7'd1}},
    '{KIND_INSERT, 32'h0000_0000, 16'h0000, 1'b1,
      '{1'b0, 32'h0, 16'h0, STATUS_OK, 7'd2}},
    '{KIND_INSERT, 32'h0000_0005, 16'h0001, 1'b1,
      '{1'b0, 32'h0, 16'h0, STATUS_OK, 7'd3}},
    '{KIND_INSERT, 32'h0000_0005, 16'h0002, 1'b0, ANY},
    '{KIND_INSERT, 32'h0000_0005, 16'h0003, 1'b0, ANY},
    '{KIND_INSERT, 32'h8000_0000, 16'h8000, 1'b0, ANY},
    '{KIND_INSERT, 32'h0000_0000, 16'h7FFF, 1'b0, ANY},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, ANY},
    '{KIND_INSERT, 32'h0000_0005, 16'h0004, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, STATUS_OK, 7'd0}},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
      '{1'b0, 32'h0, 16'h0, STATUS_EMPTY, 7'd0}},
    '{KIND_INSERT, 32'hAAAA_AAAA, 16'h5555, 1'b1,
      '{1'b0, 32'h0, 16'h0, STATUS_OK, 7'd1}},
    '{KIND_INSERT, 32'h5555_5555, 16'hAAAA, 1'b1,
      '{1'b0, 32'h0, 16'h0, STATUS_OK, 7'd2}},
    '{KIND_REMOVE, 32'h1234_5678, 16'h9ABC, 1'b0, ANY},
    '{KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, ANY}
  };

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        kind_i       = 1'b0;
  logic [31:0] event_time_i = 32'h0;
  logic [15:0] station_id_i = 16'h0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        removed_valid_o;
  logic [31:0] removed_time_o;
  logic [15:0] removed_station_o;
  logic [1:0]  status_o;
  logic [6:0]  occupancy_o;

  // typed expectation travels with the word it belongs to
  logic    word_typed = 1'b0;
  result_t word_want  = '0;

  int tx_idle_pct = 21;
  int rx_idle_pct = 54;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  int mismatches  = 0;
  int stall_cycles = 0;

  result_t pending_results[$];

  logic [31:0] model_time [QUEUE_DEPTH];
  logic [15:0] model_station [QUEUE_DEPTH];
  int          model_held = 0;

  stable_sorted_event_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .event_time_i     (event_time_i),
    .station_id_i     (station_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .removed_valid_o  (removed_valid_o),
    .removed_time_o   (removed_time_o),
    .removed_station_o(removed_station_o),
    .status_o         (status_o),
    .occupancy_o      (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t queue_apply(logic kind, logic [31:0] t, logic [15:0] id);
    result_t r;
    int      pos;
    r = '{1'b0, 32'h0, 16'h0, STATUS_OK, 7'd0};
    if (kind == KIND_INSERT) begin
      if (model_held >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = model_held;
        for (int i = 0; i < model_held; i++) begin
          if (model_time[i] > t) begin
            pos = i;
            break;
          end
        end
        for (int i = model_held; i > pos; i--) begin
          model_time[i]    = model_time[i-1];
          model_station[i] = model_station[i-1];
        end
        model_time[pos]    = t;
        model_station[pos] = id;
        model_held++;
      end
    end else begin
      if (model_held == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.found    = 1'b1;
        r.evt_time = model_time[0];
        r.station  = model_station[0];
        for (int i = 1; i < model_held; i++) begin
          model_time[i-1]    = model_time[i];
          model_station[i-1] = model_station[i];
        end
        model_held--;
      end
    end
    r.occupancy = 7'(model_held);
    return r;
  endfunction

  task automatic offer_word(logic kind, logic [31:0] t, logic [15:0] id, logic typed,
                            result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    event_time_i <= t;
    station_id_i <= id;
    word_typed   <= typed;
    word_want    <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // scoreboard: outputs are checked before the same-edge input is predicted
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t model;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (removed_valid_o !== want.found) begin
          $error("removed_valid: expected %0d, got %0d", want.found, removed_valid_o);
          mismatches++;
        end
        if (removed_time_o !== want.evt_time) begin
          $error("removed_time: expected %0h, got %0h", want.evt_time, removed_time_o);
          mismatches++;
        end
        if (removed_station_o !== want.station) begin
          $error("removed_station: expected %0h, got %0h", want.station, removed_station_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          mismatches++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      model = queue_apply(kind_i, event_time_i, station_id_i);
      pending_results.push_back(word_typed ? word_want : model);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stable_sorted_event_queue_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int          sent;
    int          seg;
    int          seg_len;
    int          ins_pct;
    logic        kind;
    logic [31:0] t;
    logic [15:0] id;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      offer_word(ROWS[r].kind, ROWS[r].evt_time, ROWS[r].station, ROWS[r].typed,
                 ROWS[r].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 54;
        end
        1: begin
          tx_idle_pct = 54;
          rx_idle_pct = 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      sent = 0;
      seg  = 0;
      // alternate fill, drain and mixed runs so full and empty are both hit
      while (sent < RAND_PER_PHASE) begin
        seg_len = $urandom_range(110, 40);
        if (seg_len > RAND_PER_PHASE - sent) begin
          seg_len = RAND_PER_PHASE - sent;
        end
        case (seg % 3)
          0:       ins_pct = 92;
          1:       ins_pct = 8;
          default: ins_pct = 50;
        endcase
        repeat (seg_len) begin
          kind = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
          case ($urandom_range(3))
            0, 1:    t = 32'($urandom_range(15));
            2:       t = $urandom;
            default: t = 32'hFFFF_FFF0 | 32'($urandom_range(15));
          endcase
          id = 16'($urandom);
          offer_word(kind, t, id, 1'b0, ANY);
          sent++;
        end
        seg++;
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stable_sorted_event_queue_test: PASS");
    end else begin
      $display("stable_sorted_event_queue_test: FAIL");
    end
    $finish;
  end

endmodule
